// ===== src/hptnd_pkg.sv =====
// ----------------------------------------------------------------------------
// hptnd_pkg
// Shared types and constants of the hot pixel detector: register indexes,
// the per-pixel flag group passed from the front end to the back end and the
// depth of the queue between them.
// ----------------------------------------------------------------------------
package hptnd_pkg;

  // words the queue between front and back end can hold
  localparam int unsigned QUEUE_DEPTH = 4;

  // configuration register indexes (address bit 2)
  typedef enum logic {
    REG_HOT_RATIO = 1'b0,
    REG_PLANE_ID  = 1'b1
  } hptnd_reg_e;

  // classification of one centre pixel
  typedef struct packed {
    logic border;
    logic last;
  } hptnd_flags_t;

endpackage

// ===== src/hot_pixel_trimmed_neighbour_detector_unit.sv =====
// Path: a pixel's verdict leaves FRAME_WIDTH+1 words after the pixel is
//   taken, then passes the line store read, the queue and 6 back end stages.
// Throughput: one word per cycle while in_stall_o is low, set by one line
//   store read per word; the first FRAME_WIDTH+1 words of a frame give no verdict.
// Reset: position counters, window, queue and pipeline clear at once; the
//   line store RAM is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// hot_pixel_trimmed_neighbour_detector_unit
// Hot pixel detector over a 3x3 window with a trimmed neighbour sum:
// configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
module hot_pixel_trimmed_neighbour_detector_unit #(
  parameter int unsigned FRAME_WIDTH  = 256,
  parameter int unsigned FRAME_HEIGHT = 256,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel words in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] hit_count_i,
  // verdict words out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  plane_o,
  output logic [7:0]  pixel_col_o,
  output logic [7:0]  pixel_row_o,
  output logic        is_hot_o,
  output logic        on_border_o,
  output logic [18:0] neighbour_sum_o,
  output logic        frame_done_o
);
  import hptnd_pkg::*;

  localparam int unsigned CW  = $clog2(FRAME_WIDTH);
  localparam int unsigned RW  = $clog2(FRAME_HEIGHT + 2);
  localparam int unsigned EW  = 9 * COUNT_BITS + CW + RW + 2;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]     hot_ratio_q;
  logic [3:0]     plane_id_q;
  logic           cfg_wr;
  hptnd_reg_e     reg_idx;

  logic           push, pop, q_valid;
  logic [EW-1:0]  entry, q_data;
  logic [QCW-1:0] q_count;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = hptnd_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hot_ratio_q <= 8'd10;
      plane_id_q  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HOT_RATIO: hot_ratio_q <= pwdata[7:0];
        REG_PLANE_ID:  plane_id_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (reg_idx)
        REG_HOT_RATIO: prdata = {24'd0, hot_ratio_q};
        REG_PLANE_ID:  prdata = {28'd0, plane_id_q};
        default:       prdata = '0;
      endcase
    end
  end

  hptnd_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .COUNT_BITS   (COUNT_BITS),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .hit_count_i (hit_count_i),
    .q_count_i   (q_count),
    .push_o      (push),
    .entry_o     (entry)
  );

  hptnd_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data),
    .count_o (q_count)
  );

  hptnd_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .q_pop_o         (pop),
    .hot_ratio_i     (hot_ratio_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_col_o     (pixel_col_o),
    .pixel_row_o     (pixel_row_o),
    .is_hot_o        (is_hot_o),
    .on_border_o     (on_border_o),
    .neighbour_sum_o (neighbour_sum_o),
    .frame_done_o    (frame_done_o)
  );

  // plane number is driven beside every verdict; the user writes it only while idle, the block does not enforce this
  assign plane_o = plane_id_q;

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> q_count < QCW'(QUEUE_DEPTH))
    else $error("front end pushed into a full queue");
  a_stall_on_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count == QCW'(QUEUE_DEPTH) |-> in_stall_o)
    else $error("input taken while queue full");
  a_pop_when_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("back end popped an empty queue");
`endif

endmodule

// ===== src/hptnd_ram.sv =====
// ----------------------------------------------------------------------------
// hptnd_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
module hptnd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/hptnd_front.sv =====
// ----------------------------------------------------------------------------
// hptnd_front
// Front end: takes pixel counts in raster order, tracks the input position,
// keeps the two line stores in one RAM and the 3x3 window, and pushes each
// centre pixel with its masked neighbours and border flags into the queue.
// ----------------------------------------------------------------------------
module hptnd_front #(
  parameter int unsigned FRAME_WIDTH  = 256,
  parameter int unsigned FRAME_HEIGHT = 256,
  parameter int unsigned COUNT_BITS   = 16,
  parameter int unsigned QUEUE_DEPTH  = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [15:0]                         hit_count_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_count_i,
  output logic                                push_o,
  output logic [9*COUNT_BITS + $clog2(FRAME_WIDTH) + $clog2(FRAME_HEIGHT+2) + 1:0]
                                              entry_o
);
  import hptnd_pkg::*;

  localparam int unsigned CB  = COUNT_BITS;
  localparam int unsigned CW  = $clog2(FRAME_WIDTH);
  localparam int unsigned RW  = $clog2(FRAME_HEIGHT + 2);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  // input position
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // stage 1 (line store read data arrives)
  logic          s1_valid_q;
  logic [CB-1:0] s1_val_q;
  logic [CW-1:0] s1_col_q;
  logic          s1_have_q;
  logic [CW-1:0] s1_cc_q;
  logic [RW-1:0] s1_cr_q;
  logic          s1_top_q, s1_bot_q, s1_left_q, s1_right_q;
  logic          s1_last_q;

  logic          in_fire;
  logic [QCW:0]  used;
  logic [CB-1:0] val;
  logic          have;
  logic [CW-1:0] cc;
  logic [RW-1:0] cr;
  logic          last;

  logic [2*CB-1:0] ram_rdata;
  logic [CB-1:0]   up, lo;

  logic [2:0][2:0][CB-1:0] win_q, win_d;
  logic [7:0][CB-1:0]      nb;
  hptnd_flags_t            flags;

  // credit check: queue words plus the word in flight
  assign used       = {1'b0, q_count_i} + {{QCW{1'b0}}, s1_valid_q};
  assign in_stall_o = (used >= (QCW+1)'(QUEUE_DEPTH));
  assign in_fire    = in_valid_i && !in_stall_o;

  // counts past the last row are flush words
  assign val = (row_q < RW'(FRAME_HEIGHT)) ? CB'(hit_count_i) : '0;

  // centre position belonging to the current input position
  always_comb begin
    have = 1'b0;
    cc   = '0;
    cr   = '0;
    if (col_q != '0 && row_q != '0) begin
      have = 1'b1;
      cc   = col_q - 1'b1;
      cr   = row_q - 1'b1;
    end else if (col_q == '0 && row_q >= RW'(2)) begin
      have = 1'b1;
      cc   = CW'(FRAME_WIDTH - 1);
      cr   = row_q - RW'(2);
    end
  end

  assign last = (col_q == '0) && (row_q == RW'(FRAME_HEIGHT + 1));

  // next input position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (col_q == CW'(FRAME_WIDTH - 1)) begin
      col_d = '0;
      row_d = row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      if (in_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_val_q   <= val;
      s1_col_q   <= col_q;
      s1_have_q  <= have;
      s1_cc_q    <= cc;
      s1_cr_q    <= cr;
      s1_top_q   <= (cr == '0);
      s1_bot_q   <= (cr == RW'(FRAME_HEIGHT - 1));
      s1_left_q  <= (cc == '0);
      s1_right_q <= (cc == CW'(FRAME_WIDTH - 1));
      s1_last_q  <= last;
    end
  end

  // both line stores in one word: upper row high, lower row low
  hptnd_ram #(
    .WIDTH (2 * CB),
    .DEPTH (FRAME_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i ({lo, s1_val_q}),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign up = ram_rdata[2*CB-1:CB];
  assign lo = ram_rdata[CB-1:0];

  // window shift: new column enters on the right
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = up;
    win_d[1][2] = lo;
    win_d[2][2] = s1_val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  // neighbours outside the frame read as zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i * 3 + j < 4) begin
          nb[i*3+j] = ((i == 0 && s1_top_q) || (i == 2 && s1_bot_q) ||
                       (j == 0 && s1_left_q) || (j == 2 && s1_right_q)) ?
                      '0 : win_d[i][j];
        end else if (i * 3 + j > 4) begin
          nb[i*3+j-1] = ((i == 0 && s1_top_q) || (i == 2 && s1_bot_q) ||
                         (j == 0 && s1_left_q) || (j == 2 && s1_right_q)) ?
                        '0 : win_d[i][j];
        end
      end
    end
  end

  assign flags.border = s1_top_q || s1_bot_q || s1_left_q || s1_right_q;
  assign flags.last   = s1_last_q;

  assign push_o  = s1_valid_q && s1_have_q;
  assign entry_o = {win_d[1][1], s1_cc_q, s1_cr_q, flags, nb};

endmodule

// ===== src/hptnd_queue.sv =====
// ----------------------------------------------------------------------------
// hptnd_queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module hptnd_queue #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [WIDTH-1:0]               data_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output logic [WIDTH-1:0]               data_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [WIDTH-1:0]           mem_q [DEPTH];
  logic [PW-1:0]              wr_ptr_q, rd_ptr_q;
  logic [$clog2(DEPTH+1)-1:0] count_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q < $bits(count_q)'(DEPTH))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue pop while empty");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with fill level");
`endif

endmodule

// ===== src/hptnd_back.sv =====
// ----------------------------------------------------------------------------
// hptnd_back
// Back end: partial sorting network over the 8 neighbours, trimmed or full
// neighbour sum, ratio multiply and hot compare, ending in the output register.
// ----------------------------------------------------------------------------
module hptnd_back #(
  parameter int unsigned FRAME_WIDTH  = 256,
  parameter int unsigned FRAME_HEIGHT = 256,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  logic [9*COUNT_BITS + $clog2(FRAME_WIDTH) + $clog2(FRAME_HEIGHT+2) + 1:0]
                      q_data_i,
  output logic        q_pop_o,
  input  logic [7:0]  hot_ratio_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pixel_col_o,
  output logic [7:0]  pixel_row_o,
  output logic        is_hot_o,
  output logic        on_border_o,
  output logic [18:0] neighbour_sum_o,
  output logic        frame_done_o
);
  import hptnd_pkg::*;

  localparam int unsigned CB    = COUNT_BITS;
  localparam int unsigned CW    = $clog2(FRAME_WIDTH);
  localparam int unsigned RW    = $clog2(FRAME_HEIGHT + 2);
  localparam int unsigned TAG_W = CB + CW + RW + 2;
  localparam int unsigned HW    = CB + 2;
  localparam int unsigned SW    = CB + 3;
  localparam int unsigned PRW   = SW + 8;

  // compare and exchange: {high, low}
  function automatic logic [2*CB-1:0] cas(input logic [CB-1:0] a, input logic [CB-1:0] b);
    cas = (a > b) ? {a, b} : {b, a};
  endfunction

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  logic [TAG_W-1:0] tag1_q, tag2_q, tag3_q, tag4_q, tag5_q, tag6_q;
  logic [7:0][CB-1:0] l0, l1, l2, l3, l4, l5;
  logic [7:0][CB-1:0] srt1_q, srt2_q;
  logic [HW-1:0]  mid_q, edge_q;
  logic [SW-1:0]  sum4_q, sum5_q, sum6_q;
  logic [PRW-1:0] prod_q;
  logic           hot6_q;
  logic [CB-1:0]  count5;
  hptnd_flags_t   flags3, flags6;

  // ready chain from the output register back to the queue
  assign rdy6    = !v6_q || !out_stall_i;
  assign rdy5    = !v5_q || rdy6;
  assign rdy4    = !v4_q || rdy5;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign q_pop_o = q_valid_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= q_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  // sorting layers 1 to 3
  always_comb begin
    l0 = q_data_i[8*CB-1:0];
    l1 = l0;
    {l1[1], l1[0]} = cas(l0[0], l0[1]);
    {l1[3], l1[2]} = cas(l0[2], l0[3]);
    {l1[5], l1[4]} = cas(l0[4], l0[5]);
    {l1[7], l1[6]} = cas(l0[6], l0[7]);
    l2 = l1;
    {l2[2], l2[0]} = cas(l1[0], l1[2]);
    {l2[3], l2[1]} = cas(l1[1], l1[3]);
    {l2[6], l2[4]} = cas(l1[4], l1[6]);
    {l2[7], l2[5]} = cas(l1[5], l1[7]);
    l3 = l2;
    {l3[2], l3[1]} = cas(l2[1], l2[2]);
    {l3[6], l3[5]} = cas(l2[5], l2[6]);
    {l3[4], l3[0]} = cas(l2[0], l2[4]);
    {l3[7], l3[3]} = cas(l2[3], l2[7]);
  end

  // sorting layers 4 and 5: two lowest and two highest settle at the ends
  always_comb begin
    l4 = srt1_q;
    {l4[5], l4[1]} = cas(srt1_q[1], srt1_q[5]);
    {l4[6], l4[2]} = cas(srt1_q[2], srt1_q[6]);
    l5 = l4;
    {l5[4], l5[1]} = cas(l4[1], l4[4]);
    {l5[6], l5[3]} = cas(l4[3], l4[6]);
  end

  assign flags3 = hptnd_flags_t'(tag3_q[1:0]);
  assign count5 = tag5_q[TAG_W-1 -: CB];

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      srt1_q <= l3;
      tag1_q <= q_data_i[8*CB +: TAG_W];
    end
    if (rdy2) begin
      srt2_q <= l5;
      tag2_q <= tag1_q;
    end
    if (rdy3) begin
      mid_q  <= HW'(srt2_q[2]) + HW'(srt2_q[3]) + HW'(srt2_q[4]) + HW'(srt2_q[5]);
      edge_q <= HW'(srt2_q[0]) + HW'(srt2_q[1]) + HW'(srt2_q[6]) + HW'(srt2_q[7]);
      tag3_q <= tag2_q;
    end
    if (rdy4) begin
      sum4_q <= SW'(mid_q) + (flags3.border ? SW'(edge_q) : '0);
      tag4_q <= tag3_q;
    end
    if (rdy5) begin
      prod_q <= PRW'(hot_ratio_i) * PRW'(sum4_q);
      sum5_q <= sum4_q;
      tag5_q <= tag4_q;
    end
    if (rdy6) begin
      hot6_q <= (PRW'(count5) > prod_q);
      sum6_q <= sum5_q;
      tag6_q <= tag5_q;
    end
  end

  // output fields
  assign flags6          = hptnd_flags_t'(tag6_q[1:0]);
  assign out_valid_o     = v6_q;
  assign pixel_col_o     = 8'(tag6_q[RW+2 +: CW]);
  assign pixel_row_o     = 8'(tag6_q[2 +: RW]);
  assign is_hot_o        = hot6_q;
  assign on_border_o     = flags6.border;
  assign neighbour_sum_o = 19'(sum6_q);
  assign frame_done_o    = flags6.last;

`ifndef SYNTHESIS
  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> v1_q)
    else $error("popped word did not enter the pipeline");
  a_last_on_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> on_border_o && pixel_col_o == 8'(FRAME_WIDTH - 1))
    else $error("frame end flagged away from the last column");
  a_trim_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> srt2_q[0] <= srt2_q[1] && srt2_q[6] <= srt2_q[7] &&
             srt2_q[1] <= srt2_q[2] && srt2_q[1] <= srt2_q[3] &&
             srt2_q[1] <= srt2_q[4] && srt2_q[1] <= srt2_q[5] &&
             srt2_q[2] <= srt2_q[6] && srt2_q[3] <= srt2_q[6] &&
             srt2_q[4] <= srt2_q[6] && srt2_q[5] <= srt2_q[6])
    else $error("middle four not between the dropped values");
`endif

endmodule
